// ----- design/keypad_scan_digit_scroller_top_defines.svh -----
// ----------------------------------------------------------------------------
// keypad_scan_digit_scroller_top_defines
// Assertion macros used by the keypad scanner top.
// ----------------------------------------------------------------------------
`ifndef KEYPAD_SCAN_DIGIT_SCROLLER_TOP_DEFINES_SVH
`define KEYPAD_SCAN_DIGIT_SCROLLER_TOP_DEFINES_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define KSDS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define KSDS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- design/ksds_pkg.sv -----
// ----------------------------------------------------------------------------
// ksds_pkg
// Types and constants shared by the keypad scanner front, back and top.
// ----------------------------------------------------------------------------
package ksds_pkg;

  localparam logic [7:0] ROW_TOP  = 8'h80;  // row pattern for row zero
  localparam logic [2:0] POS_LAST = 3'd7;   // rightmost display position

  // Column readback codes that mean a key.
  localparam logic [3:0] COL_A = 4'h8;
  localparam logic [3:0] COL_B = 4'h4;
  localparam logic [3:0] COL_C = 4'h2;
  localparam logic [3:0] COL_D = 4'h1;

  // One display job, handed from the front to the back.
  typedef struct packed {
    logic       blank;      // emit a blank write for every digit first
    logic       show;       // rewrite the buffered digits
    logic       l2r;        // scroll direction, 1 is left to right
    logic [3:0] count;      // digits held after this word
    logic [7:0] row_drive;  // row pattern for the next scan
  } cmd_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_BLANK,
    B_SHOW,
    B_QUIET
  } bstate_t;

endpackage

// ----- design/ksds_front.sv -----
// ----------------------------------------------------------------------------
// ksds_front
// Decode a poll word, update scan, hold and buffer state, issue a display job.
// ----------------------------------------------------------------------------
module ksds_front #(
  parameter int DIGITS = 8
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [3:0]              column_bits,
  input  logic                    direction_button,
  input  logic                    q_ready,
  output logic                    q_push,
  output ksds_pkg::cmd_t          q_cmd,
  output logic [DIGITS-1:0][3:0]  q_buf
);
  import ksds_pkg::*;

  localparam logic [3:0] FULL = 4'(DIGITS);

  logic [1:0]             row;
  logic                   dir;
  logic [3:0]             cnt;
  logic                   held;
  logic [3:0]             newest;
  logic [DIGITS-1:0][3:0] buffer;

  logic [1:0]             row_next;
  logic                   dir_next;
  logic [3:0]             cnt_base;
  logic [3:0]             cnt_next;
  logic                   held_keep;
  logic                   held_next;
  logic                   key_valid;
  logic [3:0]             col_off;
  logic [3:0]             key;
  logic                   append;
  logic [DIGITS-1:0][3:0] buffer_next;

  assign in_ready = q_ready;
  assign q_push   = in_valid & in_ready;

  always_comb begin
    key_valid = 1'b1;
    case (column_bits)
      COL_A:   col_off = 4'd1;
      COL_B:   col_off = 4'd2;
      COL_C:   col_off = 4'd3;
      COL_D:   col_off = 4'd4;
      default: begin
        col_off   = 4'd0;
        key_valid = 1'b0;
      end
    endcase
  end

  // Key 16 wraps to 0 in four bits.
  assign key      = {row, 2'b00} + col_off;
  assign row_next = row + 2'd1;
  assign dir_next = dir ^ direction_button;
  assign cnt_base = direction_button ? 4'd0 : cnt;

  // Hold only while the same key stays down over a non-empty buffer.
  assign held_keep = held & key_valid & (cnt_base != 4'd0) & (key == newest);
  assign append    = key_valid & ~held_keep;
  assign held_next = held_keep | append;

  always_comb begin
    buffer_next = buffer;
    cnt_next    = cnt_base;
    if (append) begin
      if (cnt_base >= FULL) begin
        // drop the oldest digit
        for (int j = 0; j < DIGITS - 1; j++) begin
          buffer_next[j] = buffer[j+1];
        end
        buffer_next[DIGITS-1] = key;
        cnt_next = FULL;
      end else begin
        for (int j = 0; j < DIGITS; j++) begin
          if (cnt_base == 4'(j)) begin
            buffer_next[j] = key;
          end
        end
        cnt_next = cnt_base + 4'd1;
      end
    end
  end

  always_comb begin
    q_cmd.blank     = direction_button;
    q_cmd.show      = append;
    q_cmd.l2r       = dir_next;
    q_cmd.count     = cnt_next;
    q_cmd.row_drive = ROW_TOP >> row_next;
    q_buf           = buffer_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row  <= 2'd0;
      dir  <= 1'b0;
      cnt  <= 4'd0;
      held <= 1'b0;
    end else if (q_push) begin
      row  <= row_next;
      dir  <= dir_next;
      cnt  <= cnt_next;
      held <= held_next;
    end
  end

  always_ff @(posedge clk) begin
    if (q_push) begin
      buffer <= buffer_next;
      if (append) begin
        newest <= key;
      end
    end
  end

endmodule

// ----- design/ksds_queue.sv -----
// ----------------------------------------------------------------------------
// ksds_queue
// Two-entry queue between front and back.
// ----------------------------------------------------------------------------
module ksds_queue #(
  parameter int W = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  output logic         push_ready,
  input  logic [W-1:0] push_data,
  output logic         pop_valid,
  input  logic         pop,
  output logic [W-1:0] pop_data
);

  logic [1:0][W-1:0] mem;
  logic              wp;
  logic              rp;
  logic [1:0]        level;

  assign push_ready = (level != 2'd2);
  assign pop_valid  = (level != 2'd0);
  assign pop_data   = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= 1'b0;
      rp    <= 1'b0;
      level <= 2'd0;
    end else begin
      if (push) begin
        wp <= ~wp;
      end
      if (pop) begin
        rp <= ~rp;
      end
      case ({push, pop})
        2'b10:   level <= level + 2'd1;
        2'b01:   level <= level - 2'd1;
        default: level <= level;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp] <= push_data;
    end
  end

endmodule

// ----- design/ksds_back.sv -----
// ----------------------------------------------------------------------------
// ksds_back
// Sequence one display job into result words through an output register.
// ----------------------------------------------------------------------------
module ksds_back #(
  parameter int DIGITS = 8
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    q_valid,
  output logic                    q_ready,
  input  ksds_pkg::cmd_t          q_cmd,
  input  logic [DIGITS-1:0][3:0]  q_buf,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [7:0]              row_drive,
  output logic                    disp_valid,
  output logic                    disp_blank,
  output logic [2:0]              disp_pos,
  output logic [3:0]              disp_digit,
  output logic                    last
);
  import ksds_pkg::*;

  localparam int         IDXW     = (DIGITS > 1) ? $clog2(DIGITS) : 1;
  localparam logic [2:0] IDX_LAST = 3'(DIGITS - 1);

  bstate_t                state;
  bstate_t                state_next;
  logic [2:0]             idx;
  logic [2:0]             idx_next;
  cmd_t                   cmd;
  logic [DIGITS-1:0][3:0] buffer;

  logic       room;
  logic       emit;
  logic       r_valid;
  logic       r_blank;
  logic [2:0] r_pos;
  logic [3:0] r_digit;
  logic       r_last;
  logic [3:0] rd_sel;
  logic       blank_done;
  logic       show_done;

  assign room       = ~out_valid | out_ready;
  assign blank_done = (idx == IDX_LAST);
  assign show_done  = ({1'b0, idx} == cmd.count - 4'd1);
  // newest digit first
  assign rd_sel     = cmd.count - 4'd1 - {1'b0, idx};

  always_comb begin
    state_next = state;
    idx_next   = idx;
    q_ready    = 1'b0;
    emit       = 1'b0;
    r_valid    = 1'b0;
    r_blank    = 1'b0;
    r_pos      = 3'd0;
    r_digit    = 4'd0;
    r_last     = 1'b0;
    case (state)
      B_IDLE: begin
        if (q_valid) begin
          q_ready  = 1'b1;
          idx_next = 3'd0;
          if (q_cmd.blank) begin
            state_next = B_BLANK;
          end else if (q_cmd.show) begin
            state_next = B_SHOW;
          end else begin
            state_next = B_QUIET;
          end
        end
      end
      B_BLANK: begin
        if (room) begin
          emit    = 1'b1;
          r_valid = 1'b1;
          r_blank = 1'b1;
          r_pos   = idx;
          r_last  = blank_done & ~cmd.show;
          if (blank_done) begin
            idx_next   = 3'd0;
            state_next = cmd.show ? B_SHOW : B_IDLE;
          end else begin
            idx_next = idx + 3'd1;
          end
        end
      end
      B_SHOW: begin
        if (room) begin
          emit    = 1'b1;
          r_valid = 1'b1;
          r_pos   = cmd.l2r ? idx : POS_LAST - idx;
          r_digit = buffer[rd_sel[IDXW-1:0]];
          r_last  = show_done;
          if (show_done) begin
            state_next = B_IDLE;
          end else begin
            idx_next = idx + 3'd1;
          end
        end
      end
      B_QUIET: begin
        if (room) begin
          emit       = 1'b1;
          r_last     = 1'b1;
          state_next = B_IDLE;
        end
      end
      default: begin
        state_next = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      idx       <= 3'd0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_ready) begin
      cmd    <= q_cmd;
      buffer <= q_buf;
    end
    if (emit) begin
      row_drive  <= cmd.row_drive;
      disp_valid <= r_valid;
      disp_blank <= r_blank;
      disp_pos   <= r_pos;
      disp_digit <= r_digit;
      last       <= r_last;
    end
  end

endmodule

// ----- design/keypad_scan_digit_scroller_top.sv -----
// ----------------------------------------------------------------------------
// keypad_scan_digit_scroller_top
// 4x4 keypad row scanner with a scrolling hex display of the keys entered.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready): one word per poll tick, carrying the
//   column readback for the row now driven and the direction switch.
// Output channel (out_valid/out_ready): one word per display write; a tick
//   gives up to DIGITS+1 words, or one quiet word with disp_valid low. The
//   final word of a tick has last set; row_drive is the next row pattern.
// The front decodes the tick and updates scan state in the accept cycle,
//   then posts a job into a two-entry queue. The back loads a job while
//   idle, then emits its words in turn, stalling while the output register
//   is full, and takes no new job until the last word is out; it sets the rate.
// A tick's first word goes through the queue, job register and output register.
// Reset clears row index, count, key hold and direction (right to left);
//   the digit buffer is not cleared, since an empty buffer is never read.
// A stalled receiver holds the output register; the back then stops, the
//   queue fills and in_ready drops once it holds two jobs.
// ----------------------------------------------------------------------------
module keypad_scan_digit_scroller_top #(
  parameter int DIGITS = 8
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [3:0] column_bits,
  input  logic       direction_button,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] row_drive,
  output logic       disp_valid,
  output logic       disp_blank,
  output logic [2:0] disp_pos,
  output logic [3:0] disp_digit,
  output logic       last
);
  import ksds_pkg::*;

  `include "keypad_scan_digit_scroller_top_defines.svh"

  localparam int QW = $bits(cmd_t) + DIGITS * 4;

  // front to queue
  logic                   f_push;
  logic                   f_ready;
  cmd_t                   f_cmd;
  logic [DIGITS-1:0][3:0] f_buf;

  // queue to back
  logic                   b_valid;
  logic                   b_ready;
  logic [QW-1:0]          b_data;
  cmd_t                   b_cmd;
  logic [DIGITS-1:0][3:0] b_buf;

  assign {b_cmd, b_buf} = b_data;

  // Decode the tick and advance scan state.
  ksds_front #(
    .DIGITS (DIGITS)
  ) u_front (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .column_bits      (column_bits),
    .direction_button (direction_button),
    .q_ready          (f_ready),
    .q_push           (f_push),
    .q_cmd            (f_cmd),
    .q_buf            (f_buf)
  );

  // Decouple: buffer jobs while the receiver stalls.
  ksds_queue #(
    .W (QW)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (f_push),
    .push_ready (f_ready),
    .push_data  ({f_cmd, f_buf}),
    .pop_valid  (b_valid),
    .pop        (b_ready),
    .pop_data   (b_data)
  );

  // Expand each job into display writes.
  ksds_back #(
    .DIGITS (DIGITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (b_valid),
    .q_ready    (b_ready),
    .q_cmd      (b_cmd),
    .q_buf      (b_buf),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .row_drive  (row_drive),
    .disp_valid (disp_valid),
    .disp_blank (disp_blank),
    .disp_pos   (disp_pos),
    .disp_digit (disp_digit),
    .last       (last)
  );

  // A quiet word closes its tick and writes nothing.
  `KSDS_ASSERT_NOW(a_quiet_word, out_valid && !disp_valid, last && !disp_blank && disp_pos == 3'd0 && disp_digit == 4'd0, "quiet word malformed")

  // Blank writes carry no digit.
  `KSDS_ASSERT_NOW(a_blank_word, out_valid && disp_blank, disp_valid && disp_digit == 4'd0, "blank write carries a digit")

  // Row pattern is a single bit in the upper nibble.
  `KSDS_ASSERT_NOW(a_row_drive, out_valid, $onehot(row_drive) && row_drive[3:0] == 4'd0, "bad row pattern")

  // A job is only taken from the queue when one is waiting.
  `KSDS_ASSERT_NOW(a_queue_pop, b_ready, b_valid, "pop from empty queue")

endmodule
